// ===== sv/epts_pkg.sv =====
package epts_pkg;

  localparam logic [7:0] PAGE_BYTES = 8'd64;

  localparam logic [15:0] HW_BYTES_RST   = 16'd64;
  localparam logic [15:0] USER_BYTES_RST = 16'd32704;
  localparam logic [15:0] VLEN_RST       = 16'd0;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_READ  = 3'b010,
    MODE_WRITE = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_COMPLETE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_READ  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_BUSY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_HW_BYTES   = 2'd0,
    REG_USER_BYTES = 2'd1,
    REG_VALID_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] hw_bytes;
    logic [15:0] user_bytes;
    logic [15:0] valid_len;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        read_data_sent;
    logic [15:0] region_start;
    logic [15:0] write_offset;
    logic [15:0] region_length;
    logic [7:0]  page_length;
    logic [1:0]  cur_buffer;
    logic        last_status;
  } state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] buffer_id;
    logic       status_ok;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] eeprom_address;
    logic [15:0] buffer_offset;
    logic [15:0] byte_count;
    logic [1:0]  target_buffer;
    logic        busy;
    logic        last_ok;
  } result_t;

endpackage

// ===== sv/epts_cfg_if.sv =====
interface epts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/epts_req_if.sv =====
interface epts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] buffer_id;
  logic       status_ok;

  modport source (output valid, output op, output buffer_id, output status_ok, input ready);
  modport sink   (input valid, input op, input buffer_id, input status_ok, output ready);
endinterface

// ===== sv/epts_rsp_if.sv =====
interface epts_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] eeprom_address;
  logic [15:0] buffer_offset;
  logic [15:0] byte_count;
  logic [1:0]  target_buffer;
  logic        busy_res;
  logic        last_ok;

  modport source (output valid, output result_kind, output eeprom_address,
                  output buffer_offset, output byte_count, output target_buffer,
                  output busy_res, output last_ok, input ready);
  modport sink   (input valid, input result_kind, input eeprom_address,
                  input buffer_offset, input byte_count, input target_buffer,
                  input busy_res, input last_ok, output ready);
endinterface

// ===== sv/epts_step.sv =====
module epts_step (
  input  epts_pkg::state_t  st,
  input  epts_pkg::cfg_t    cfg,
  input  epts_pkg::item_t   item,
  output epts_pkg::state_t  st_next,
  output epts_pkg::result_t res
);

  localparam logic [1:0] BUF_HW        = 2'd0;
  localparam logic [1:0] BUF_VALIDATED = 2'd2;

  logic        is_launch;
  logic [15:0] start_sel;
  logic [15:0] length_sel;
  logic [15:0] adv_offset;
  logic [15:0] page_off;
  logic [15:0] page_base;
  logic [15:0] page_start;
  logic [15:0] remain;
  logic [7:0]  page;
  logic [15:0] page_addr;

  always_comb begin
    is_launch = (item.op == epts_pkg::OP_READ) || (item.op == epts_pkg::OP_WRITE);
    start_sel = (item.buffer_id == BUF_HW) ? 16'd0 : cfg.hw_bytes;
    if (item.buffer_id == BUF_HW) begin
      length_sel = cfg.hw_bytes;
    end else if (item.buffer_id == BUF_VALIDATED && cfg.valid_len != 16'd0) begin
      length_sel = cfg.valid_len;
    end else begin
      length_sel = cfg.user_bytes;
    end
    adv_offset = item.status_ok ? st.write_offset + {8'd0, st.page_length} : st.write_offset;
    page_off   = is_launch ? 16'd0 : adv_offset;
    page_base  = is_launch ? length_sel : st.region_length;
    page_start = is_launch ? start_sel : st.region_start;
    remain     = page_base - page_off;
    page       = (remain < {8'd0, epts_pkg::PAGE_BYTES}) ? remain[7:0] : epts_pkg::PAGE_BYTES;
    page_addr  = page_start + page_off;
  end

  always_comb begin
    st_next            = st;
    res                = '0;
    res.kind           = epts_pkg::KIND_NONE;
    case (item.op)
      epts_pkg::OP_READ, epts_pkg::OP_WRITE: begin
        if (st.mode != epts_pkg::MODE_IDLE) begin
          res.kind = epts_pkg::KIND_BUSY;
        end else begin
          st_next.cur_buffer   = item.buffer_id;
          st_next.region_start = start_sel;
          st_next.last_status  = 1'b1;
          if (item.op == epts_pkg::OP_READ) begin
            st_next.mode           = epts_pkg::MODE_READ;
            st_next.read_data_sent = 1'b0;
            res.kind               = epts_pkg::KIND_WRITE;
            res.eeprom_address     = start_sel;
          end else begin
            st_next.mode          = epts_pkg::MODE_WRITE;
            st_next.write_offset  = 16'd0;
            st_next.region_length = length_sel;
            st_next.page_length   = page;
            res.kind              = epts_pkg::KIND_WRITE;
            res.eeprom_address    = page_addr;
            res.byte_count        = {8'd0, page};
          end
        end
      end
      epts_pkg::OP_COMPLETE: begin
        st_next.last_status = item.status_ok;
        if (st.mode == epts_pkg::MODE_READ) begin
          if (st.read_data_sent) begin
            st_next.mode = epts_pkg::MODE_IDLE;
            res.kind     = epts_pkg::KIND_DONE;
          end else begin
            st_next.read_data_sent = 1'b1;
            st_next.last_status    = 1'b1;
            res.kind               = epts_pkg::KIND_READ;
            res.eeprom_address     = st.region_start;
            res.byte_count         = (st.cur_buffer == BUF_HW) ? cfg.hw_bytes : cfg.user_bytes;
          end
        end else if (st.mode == epts_pkg::MODE_WRITE) begin
          st_next.write_offset = adv_offset;
          if (adv_offset < st.region_length) begin
            st_next.page_length = page;
            st_next.last_status = 1'b1;
            res.kind            = epts_pkg::KIND_WRITE;
            res.eeprom_address  = page_addr;
            res.buffer_offset   = adv_offset;
            res.byte_count      = {8'd0, page};
          end else begin
            st_next.mode = epts_pkg::MODE_IDLE;
            res.kind     = epts_pkg::KIND_DONE;
          end
        end else begin
          st_next.mode = epts_pkg::MODE_IDLE;
        end
      end
      default: begin
        res.kind = epts_pkg::KIND_NONE;
      end
    endcase
    res.target_buffer = st_next.cur_buffer;
    res.busy          = (st_next.mode != epts_pkg::MODE_IDLE);
    res.last_ok       = st_next.last_status;
  end

endmodule

// ===== sv/eeprom_page_transfer_sequencer.sv =====
// A result is registered and presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; the output register drains while the
// next transaction is taken, so req.ready only drops when rsp is stalled.
// Reset (synchronous, rst high): idle, output empty, registers at defaults
// 64 / 32704 / 0, last status one. No memories to clear.
module eeprom_page_transfer_sequencer (
  input  logic                clk,
  input  logic                rst,
  epts_cfg_if.sink            cfg,
  epts_req_if.sink            req,
  epts_rsp_if.source          rsp
);

  epts_pkg::cfg_t    cfg_q;
  epts_pkg::state_t  st;
  epts_pkg::state_t  st_next;
  epts_pkg::item_t   item;
  epts_pkg::result_t res;
  epts_pkg::result_t out_q;
  logic              out_valid;
  logic              accept;

  assign cfg.ready = 1'b1;
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign item.op        = req.op;
  assign item.buffer_id = req.buffer_id;
  assign item.status_ok = req.status_ok;

  epts_step u_step (
    .st      (st),
    .cfg     (cfg_q),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.hw_bytes   <= epts_pkg::HW_BYTES_RST;
      cfg_q.user_bytes <= epts_pkg::USER_BYTES_RST;
      cfg_q.valid_len  <= epts_pkg::VLEN_RST;
      st.mode           <= epts_pkg::MODE_IDLE;
      st.read_data_sent <= 1'b0;
      st.region_start   <= 16'd0;
      st.write_offset   <= 16'd0;
      st.region_length  <= 16'd0;
      st.page_length    <= 8'd0;
      st.cur_buffer     <= 2'd0;
      st.last_status    <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          epts_pkg::REG_HW_BYTES:   cfg_q.hw_bytes   <= cfg.data;
          epts_pkg::REG_USER_BYTES: cfg_q.user_bytes <= cfg.data;
          epts_pkg::REG_VALID_LEN:  cfg_q.valid_len  <= cfg.data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_kind    = out_q.kind;
  assign rsp.eeprom_address = out_q.eeprom_address;
  assign rsp.buffer_offset  = out_q.buffer_offset;
  assign rsp.byte_count     = out_q.byte_count;
  assign rsp.target_buffer  = out_q.target_buffer;
  assign rsp.busy_res       = out_q.busy;
  assign rsp.last_ok        = out_q.last_ok;

  a_busy_reply_flags_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.kind == epts_pkg::KIND_BUSY |-> out_q.busy)
    else $error("busy reject reported as idle");

  a_offset_in_region: assert property (@(posedge clk) disable iff (rst)
    st.mode == epts_pkg::MODE_WRITE |-> st.write_offset <= st.region_length)
    else $error("write offset beyond region length");

  a_offset_advance: assert property (@(posedge clk) disable iff (rst)
    accept && st.mode == epts_pkg::MODE_WRITE && req.op == epts_pkg::OP_COMPLETE
      && req.status_ok
    |=> st.write_offset == $past(st.write_offset + {8'd0, st.page_length}))
    else $error("offset did not advance by page length");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    accept && st.mode != epts_pkg::MODE_IDLE
      && (req.op == epts_pkg::OP_READ || req.op == epts_pkg::OP_WRITE)
    |=> $stable(st.cur_buffer) && $stable(st.region_start) && $stable(st.mode))
    else $error("rejected launch changed transfer state");

endmodule
